### rtl/sssws_pkg.sv
package sssws_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int SCAN_W      = $clog2(DIGIT_COUNT);
    localparam int PERIOD_W    = 10;
    localparam int CFG_DATA_W  = 10;

    typedef enum logic [0:0] {
        CFG_COMMON_ANODE = 1'b0,
        CFG_SPIN_PERIOD  = 1'b1
    } cfg_index_t;

    localparam logic [PERIOD_W-1:0] SPIN_PERIOD_RESET = 10'd151;

    // segment bits a..g
    localparam logic [6:0] SEG_A = 7'h01;
    localparam logic [6:0] SEG_B = 7'h02;
    localparam logic [6:0] SEG_C = 7'h04;
    localparam logic [6:0] SEG_D = 7'h08;
    localparam logic [6:0] SEG_E = 7'h10;
    localparam logic [6:0] SEG_F = 7'h20;
    localparam logic [6:0] SEG_G = 7'h40;

    localparam logic [1:0] FWD_INDEX_RESET = 2'd0;
    localparam logic [1:0] REV_INDEX_RESET = 2'd3;

    typedef struct packed {
        logic       tick_due;
        logic [7:0] time_value;
        logic       spin_enable;
        logic       spin_direction;
    } in_item_t;

    typedef struct packed {
        logic [3:0] digit_enable;
        logic [7:0] segment_drive;
    } out_item_t;

    // spinner patterns as seen by the digit currently being scanned
    typedef struct packed {
        logic [6:0] left;
        logic [6:0] right;
    } spin_view_t;

    function automatic logic [6:0] decimal_glyph(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1:    seg = SEG_B | SEG_C;
            4'd2:    seg = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4:    seg = SEG_B | SEG_C | SEG_F | SEG_G;
            4'd5:    seg = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
            4'd6:    seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd7:    seg = SEG_A | SEG_B | SEG_C;
            4'd8:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [6:0] left_frame(input logic [1:0] frame);
        logic [6:0] seg;
        case (frame)
            2'd0:    seg = SEG_A;
            2'd1:    seg = 7'h00;
            2'd2:    seg = SEG_D;
            2'd3:    seg = SEG_E | SEG_F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [6:0] right_frame(input logic [1:0] frame);
        logic [6:0] seg;
        case (frame)
            2'd0:    seg = SEG_A;
            2'd1:    seg = SEG_B | SEG_C;
            2'd2:    seg = SEG_D;
            2'd3:    seg = 7'h00;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

### rtl/seven_segment_scan_with_spinner.sv
// channel  | handshake          | payload
// input    | in_valid/in_stall  | in_data  (tick_due, time_value, spin_enable, spin_direction)
// output   | out_valid/out_stall| out_data (digit_enable, segment_drive)
// config   | cfg_write          | cfg_index, cfg_data
//
// Two registers deep: input register, then result register; one transaction
// per cycle sustained while out_stall is low.
// While a result waits under out_stall, the input register takes at most one
// more transaction; once it is full, in_stall follows out_stall in the same cycle.
// Reset: scan at digit 0, timer 0, spinner blank, common anode, period 151.
module seven_segment_scan_with_spinner (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  sssws_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output sssws_pkg::out_item_t                 out_data,
    input  logic                                 cfg_write,
    input  sssws_pkg::cfg_index_t                cfg_index,
    input  logic [sssws_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sssws_pkg::*;

    in_item_t            s1_item_reg;
    logic                s1_valid_reg, s1_valid_next;
    out_item_t           out_item_reg;
    logic                out_valid_reg, out_valid_next;
    logic                common_anode_reg;
    logic [PERIOD_W-1:0] spin_period_reg;
    logic                s2_ready;
    logic                step;
    logic                in_take;
    spin_view_t          view;
    out_item_t           result;

    assign s2_ready = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && s2_ready;
    assign in_stall = s1_valid_reg && !s2_ready;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (step)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            common_anode_reg <= 1'b1;
            spin_period_reg  <= SPIN_PERIOD_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_COMMON_ANODE: common_anode_reg <= cfg_data[0];
                    CFG_SPIN_PERIOD:  spin_period_reg  <= cfg_data[PERIOD_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_data;
        if (step)
            out_item_reg <= result;
    end

    sssws_spinner u_spinner (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (s1_item_reg),
        .spin_period (spin_period_reg),
        .view        (view)
    );

    sssws_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .time_value   (s1_item_reg.time_value),
        .view         (view),
        .common_anode (common_anode_reg),
        .result       (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg)
        else $error("held input transaction lost");

endmodule

### rtl/sssws_spinner.sv
module sssws_spinner (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  sssws_pkg::in_item_t                 item,
    input  logic [sssws_pkg::PERIOD_W-1:0]      spin_period,
    output sssws_pkg::spin_view_t               view
);
    import sssws_pkg::*;

    logic [PERIOD_W-1:0] step_timer_reg, step_timer_next;
    logic [1:0]          fwd_idx_reg, fwd_idx_next;
    logic [1:0]          rev_idx_reg, rev_idx_next;
    logic [6:0]          left_reg, left_next;
    logic [6:0]          right_reg, right_next;
    logic [PERIOD_W-1:0] timer_inc;
    logic                expired;
    logic [1:0]          frame;

    always_comb
    begin
        timer_inc       = step_timer_reg + 1'b1;
        // a period of zero expires on every tick, same as one
        expired         = item.tick_due && (timer_inc >= spin_period);
        frame           = item.spin_direction ? fwd_idx_reg : rev_idx_reg;
        step_timer_next = step_timer_reg;
        fwd_idx_next    = fwd_idx_reg;
        rev_idx_next    = rev_idx_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        if (step && item.tick_due)
        begin
            step_timer_next = expired ? '0 : timer_inc;
            if (expired && item.spin_enable)
            begin
                left_next  = left_frame(frame);
                right_next = right_frame(frame);
                if (item.spin_direction)
                    fwd_idx_next = fwd_idx_reg + 2'd1;
                else
                    rev_idx_next = rev_idx_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_timer_reg <= '0;
            fwd_idx_reg    <= FWD_INDEX_RESET;
            rev_idx_reg    <= REV_INDEX_RESET;
            left_reg       <= '0;
            right_reg      <= '0;
        end
        else
        begin
            step_timer_reg <= step_timer_next;
            fwd_idx_reg    <= fwd_idx_next;
            rev_idx_reg    <= rev_idx_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
        end
    end

    // the displayed digit sees the frame loaded in this same transaction
    assign view.left  = left_next;
    assign view.right = right_next;

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(step_timer_reg) && $stable(fwd_idx_reg) && $stable(rev_idx_reg))
        else $error("spinner state moved without a transaction");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> !((fwd_idx_reg != $past(fwd_idx_reg)) && (rev_idx_reg != $past(rev_idx_reg))))
        else $error("both spinner indices moved in one transaction");

endmodule

### rtl/sssws_scan.sv
module sssws_scan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             time_value,
    input  sssws_pkg::spin_view_t  view,
    input  logic                   common_anode,
    output sssws_pkg::out_item_t   result
);
    import sssws_pkg::*;

    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [15:0]       prod;
    logic [4:0]        quot;
    logic [7:0]        ones_wide;
    logic [3:0]        ones;
    logic [4:0]        tens_wide;
    logic [3:0]        tens;
    logic [6:0]        pattern;
    logic [3:0]        onehot;

    always_comb
    begin
        // tv / 10 as tv * 205 >> 11, exact for 8-bit values
        prod      = {8'd0, time_value} * 16'd205;
        quot      = prod[15:11];
        ones_wide = time_value - {quot, 3'b000} - {2'b00, quot, 1'b0};
        ones      = ones_wide[3:0];
        if (quot >= 5'd20)
            tens_wide = quot - 5'd20;
        else if (quot >= 5'd10)
            tens_wide = quot - 5'd10;
        else
            tens_wide = quot;
        tens = tens_wide[3:0];

        case (scan_reg)
            2'd0:    pattern = decimal_glyph(ones);
            2'd1:    pattern = decimal_glyph(tens);
            2'd2:    pattern = view.left;
            2'd3:    pattern = view.right;
            default: pattern = 7'h00;
        endcase
        onehot = 4'b0001 << scan_reg;

        if (common_anode)
        begin
            result.digit_enable  = onehot;
            result.segment_drive = ~{1'b0, pattern};
        end
        else
        begin
            result.digit_enable  = ~onehot;
            result.segment_drive = {1'b0, pattern};
        end

        scan_next = step ? scan_reg + 1'b1 : scan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= '0;
        else
            scan_reg <= scan_next;
    end

    a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> scan_reg == $past(scan_reg) + 1'b1)
        else $error("scan position did not advance");

    a_onehot_digit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(common_anode ? result.digit_enable : ~result.digit_enable))
        else $error("digit drive not one-hot");

endmodule
